// ----- src/sparse_csc_matvec_residual_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sparse matrix-vector residual block
// Each macro checks a property on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_CSC_MATVEC_RESIDUAL_MACROS_SVH
`define SPARSE_CSC_MATVEC_RESIDUAL_MACROS_SVH

`ifndef SYNTH
`define SCMR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define SCMR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SCMR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SCMR_ASSERT(lbl, prop)
`define SCMR_ASSERT_IMP(lbl, ante, cons)
`define SCMR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/scmr_pkg.sv -----
// ----------------------------------------------------------------------------
// scmr_pkg
// Shared widths, codes and types of the sparse matrix-vector residual block.
// ----------------------------------------------------------------------------
package scmr_pkg;

    localparam int ROW_W = 10;
    localparam int VAL_W = 32;
    localparam int ACC_W = 64;
    localparam int FRAC_SHIFT = 24;

    localparam logic OP_ACCUMULATE = 1'b0;
    localparam logic OP_RESIDUAL   = 1'b1;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam int FIFO_DEPTH = 3;
    localparam int LEVEL_W    = 2;

    typedef struct packed {
        logic signed [ACC_W-1:0] residual;
        logic [ROW_W-1:0]        result_row;
        logic                    saturated;
    } t_result;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic                    clipped;
    } t_entry;

endpackage

// ----- src/scmr_if.sv -----
// ----------------------------------------------------------------------------
// scmr_in_if / scmr_out_if
// Valid-ready channels for request items and residual result items.
// ----------------------------------------------------------------------------
interface scmr_in_if;
    import scmr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [ROW_W-1:0]        row_index;
    logic signed [VAL_W-1:0] matrix_value;
    logic signed [VAL_W-1:0] vector_value;
    logic signed [VAL_W-1:0] rhs_value;

    modport source (
        output valid, opcode, row_index, matrix_value, vector_value, rhs_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, row_index, matrix_value, vector_value, rhs_value,
        output ready
    );
endinterface

interface scmr_out_if;
    import scmr_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] residual;
    logic [ROW_W-1:0]        result_row;
    logic                    saturated;

    modport source (output valid, residual, result_row, saturated, input ready);
    modport sink (input valid, residual, result_row, saturated, output ready);
endinterface

// ----- src/sparse_csc_matvec_residual.sv -----
// ----------------------------------------------------------------------------
// sparse_csc_matvec_residual
// Column-compressed sparse matrix-vector product with per-row residual read.
//
//   Channel  Dir  Item
//   i_in     in   opcode, row_index, matrix_value, vector_value, rhs_value
//   o_out    out  residual, result_row, saturated (one per residual request)
//
// One item is accepted per cycle while i_in.ready is high. A residual item
// enters the output FIFO at the edge after its request is accepted and can
// leave it at the next edge. The row accumulators live in one registered-read
// memory; back-to-back updates of one row use a forwarding register. After reset
// a clearing pass zeroes every row while i_in.ready stays low. A stalled output
// stops intake once the three FIFO entries, counting a residual in flight, are used.
// ----------------------------------------------------------------------------
`include "sparse_csc_matvec_residual_macros.svh"

module sparse_csc_matvec_residual #(
    parameter int ROWS = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scmr_in_if.sink    i_in,
    scmr_out_if.source o_out
);
    import scmr_pkg::*;

    localparam int IDX_W = $clog2(ROWS);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(ROWS - 1);

    t_entry                  r_mem [ROWS];
    t_entry                  r_rd_data;

    logic                    r_clr_busy;
    logic [IDX_W-1:0]        r_clr_addr;

    logic                    r_s1_valid;
    logic                    r_s1_op;
    logic [ROW_W-1:0]        r_s1_row;
    logic                    r_s1_in_range;
    logic signed [ACC_W-1:0] r_s1_operand;

    logic                    r_wb_valid;
    logic [ROW_W-1:0]        r_wb_row;
    t_entry                  r_wb_data;

    logic                    in_accept;
    logic                    row_ok;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [ACC_W-1:0] product;
    logic signed [ACC_W-1:0] rhs_wide;

    t_entry                  cur;
    logic signed [ACC_W:0]   add_ext;
    logic signed [ACC_W:0]   sub_ext;
    logic                    add_ovf;
    logic                    sub_ovf;
    t_entry                  n_entry;
    t_result                 n_result;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    t_entry                  wr_data;

    logic                    push;
    logic [LEVEL_W-1:0]      level;
    logic                    s1_res;

    assign in_accept = i_in.valid && i_in.ready;
    assign row_ok    = (32'(i_in.row_index) < 32'(ROWS));
    assign rd_addr   = IDX_W'(i_in.row_index);
    assign product   = i_in.matrix_value * i_in.vector_value;
    assign rhs_wide  = {{(ACC_W-VAL_W-FRAC_SHIFT){i_in.rhs_value[VAL_W-1]}},
                        i_in.rhs_value, {FRAC_SHIFT{1'b0}}};

    assign s1_res   = r_s1_valid && (r_s1_op == OP_RESIDUAL);
    assign push     = s1_res;
    assign i_in.ready = !r_clr_busy &&
        (({1'b0, level} + {{LEVEL_W{1'b0}}, s1_res}) < (LEVEL_W+1)'(FIFO_DEPTH));

    // Row value as of the write that happened on the previous edge, or zero for an out-of-range row.
    always_comb begin
        if (!r_s1_in_range) begin
            cur = '0;
        end else if (r_wb_valid && (r_wb_row == r_s1_row)) begin
            cur = r_wb_data;
        end else begin
            cur = r_rd_data;
        end
    end

    assign add_ext = {cur.sum[ACC_W-1], cur.sum} + {r_s1_operand[ACC_W-1], r_s1_operand};
    assign sub_ext = {r_s1_operand[ACC_W-1], r_s1_operand} - {cur.sum[ACC_W-1], cur.sum};
    assign add_ovf = add_ext[ACC_W] != add_ext[ACC_W-1];
    assign sub_ovf = sub_ext[ACC_W] != sub_ext[ACC_W-1];

    always_comb begin
        n_entry.clipped = cur.clipped || add_ovf;
        if (add_ovf) begin
            n_entry.sum = add_ext[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_entry.sum = add_ext[ACC_W-1:0];
        end
        n_result.result_row = r_s1_row;
        n_result.saturated  = cur.clipped || sub_ovf;
        if (sub_ovf) begin
            n_result.residual = sub_ext[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            n_result.residual = sub_ext[ACC_W-1:0];
        end
    end

    always_comb begin
        wr_en   = r_clr_busy || (r_s1_valid && r_s1_in_range);
        wr_addr = r_clr_busy ? r_clr_addr : IDX_W'(r_s1_row);
        if (r_clr_busy || (r_s1_op == OP_RESIDUAL)) begin
            wr_data = '0;
        end else begin
            wr_data = n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_s1_valid <= in_accept;
            r_wb_valid <= r_s1_valid && r_s1_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op       <= i_in.opcode;
        r_s1_row      <= i_in.row_index;
        r_s1_in_range <= row_ok;
        r_s1_operand  <= (i_in.opcode == OP_RESIDUAL) ? rhs_wide : product;
        r_wb_row      <= r_s1_row;
        r_wb_data     <= wr_data;
    end

    scmr_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (n_result),
        .o_level     (level),
        .o_out       (o_out)
    );

    `SCMR_ASSERT_IMP(a_clear_blocks_input, r_clr_busy, !i_in.ready)
    `SCMR_ASSERT_IMP(a_no_work_during_clear, r_s1_valid, !r_clr_busy)
    `SCMR_ASSERT_IMP(a_fifo_no_overflow, push && (level == LEVEL_W'(FIFO_DEPTH)), o_out.valid && o_out.ready)
    `SCMR_ASSERT_NEXT(a_residual_clears_row, s1_res && r_s1_in_range, r_wb_valid && (r_wb_data.sum == '0) && !r_wb_data.clipped)

endmodule

// ----- src/scmr_out_fifo.sv -----
// ----------------------------------------------------------------------------
// scmr_out_fifo
// Small register FIFO that holds residual result items until they are taken.
// ----------------------------------------------------------------------------
module scmr_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  scmr_pkg::t_result             i_push_data,
    output logic [scmr_pkg::LEVEL_W-1:0]  o_level,
    scmr_out_if.source                    o_out
);
    import scmr_pkg::*;

    localparam int PTR_W = 2;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    t_result           r_slots [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [LEVEL_W-1:0] r_level;
    logic              pop;
    t_result           head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_slots[r_rd_ptr];

    assign o_out.valid      = (r_level != '0);
    assign o_out.residual   = head.residual;
    assign o_out.result_row = head.result_row;
    assign o_out.saturated  = head.saturated;
    assign o_level          = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
